// File: hdl/brr_pkg.sv
`default_nettype none

package brr_pkg;

   localparam int unsigned HeaderWidth  = 8;
   localparam int unsigned PayloadWidth = 64;
   localparam int unsigned SampleWidth  = 16;
   localparam int unsigned HistWidth    = 15;
   localparam int unsigned CalcWidth    = 20;

   localparam logic [3:0] RANGE_LIMIT = 4'd13;
   localparam logic [3:0] LAST_INDEX  = 4'd15;

   typedef enum logic [1:0] {
      FLT_NONE  = 2'd0,
      FLT_ONE   = 2'd1,
      FLT_TWO   = 2'd2,
      FLT_THREE = 2'd3
   } brr_filter_type;

   typedef struct packed {
      logic                    start;
      logic [3:0]              shift_range;
      brr_filter_type          filter;
      logic                    end_flag;
      logic [PayloadWidth-1:0] payload;
   } brr_entry_type;

endpackage

`default_nettype wire

// File: hdl/brr_front.sv
`default_nettype none

module brr_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [71:0]           req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  queue_full,
   output logic                       push,
   output brr_pkg::brr_entry_type     push_entry
);
   import brr_pkg::*;

   logic ended_ff;
   logic ended_in;
   logic still_ended;
   logic accept;

   // A start word reopens the stream; otherwise words after an end word are dropped.
   always_comb begin
      req_tready  = !queue_full;
      accept      = req_tvalid && req_tready;
      still_ended = ended_ff && !req_tuser;
      push        = accept && !still_ended;

      push_entry.start       = req_tuser;
      push_entry.shift_range = req_tdata[7:4];
      push_entry.filter      = brr_filter_type'(req_tdata[3:2]);
      push_entry.end_flag    = req_tdata[0];
      push_entry.payload     = req_tdata[71:8];

      ended_in = ended_ff;
      if (accept) begin
         ended_in = still_ended || req_tdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ended_ff <= 1'b0;
      end else begin
         ended_ff <= ended_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/brr_queue.sv
`default_nettype none

module brr_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire brr_pkg::brr_entry_type push_entry,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output brr_pkg::brr_entry_type     head_entry
);
   import brr_pkg::*;

   localparam int unsigned PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(DEPTH);

   brr_entry_type         slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      full       = (count_ff == CountFull);
      head_valid = (count_ff != '0);
      head_entry = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/brr_back.sv
`default_nettype none

module brr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire brr_pkg::brr_entry_type head_entry,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [15:0]                 rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);
   import brr_pkg::*;

   logic [3:0]                   index_ff;
   logic [3:0]                   index_in;
   logic signed [HistWidth-1:0]  newer_ff;
   logic signed [HistWidth-1:0]  newer_in;
   logic signed [HistWidth-1:0]  older_ff;
   logic signed [HistWidth-1:0]  older_in;
   logic                         valid_ff;
   logic                         valid_in;
   logic [SampleWidth-1:0]       sample_ff;
   logic [SampleWidth-1:0]       sample_in;
   logic                         last_ff;
   logic                         last_in;
   logic                         ended_ff;
   logic                         ended_in;

   logic                         step;
   logic                         clear_hist;
   logic [5:0]                   nib_pos;
   logic [3:0]                   nib;
   logic signed [16:0]           nib_ext;
   logic signed [16:0]           scaled;
   logic signed [CalcWidth-1:0]  base;
   logic signed [CalcWidth-1:0]  s1;
   logic signed [CalcWidth-1:0]  s2;
   logic signed [CalcWidth-1:0]  pred;
   logic signed [CalcWidth-1:0]  total;
   logic signed [SampleWidth-1:0] clamped;
   logic signed [HistWidth-1:0]  wrapped;

   always_comb begin
      step       = head_valid && (!valid_ff || rsp_tready);
      pop        = step && (index_ff == LAST_INDEX);
      clear_hist = head_entry.start && (index_ff == '0);

      // The high nibble of each byte comes first.
      nib_pos = {index_ff[3:1], ~index_ff[0], 2'b00};
      nib     = head_entry.payload[nib_pos +: 4];
      nib_ext = {{13{nib[3]}}, nib};
      scaled  = (nib_ext <<< head_entry.shift_range) >>> 1;
      if (head_entry.shift_range < RANGE_LIMIT) begin
         base = CalcWidth'(scaled);
      end else begin
         base = nib[3] ? -20'sd2048 : 20'sd0;
      end

      s1 = clear_hist ? '0 : CalcWidth'(newer_ff);
      s2 = clear_hist ? '0 : CalcWidth'(older_ff);

      case (head_entry.filter)
         FLT_NONE:  pred = '0;
         FLT_ONE:   pred = s1 + ((-s1) >>> 4);
         FLT_TWO:   pred = (s1 <<< 1) + ((s1 * -20'sd3) >>> 5) - s2 + (s2 >>> 4);
         FLT_THREE: pred = (s1 <<< 1) + ((s1 * -20'sd13) >>> 6) - s2 + ((s2 * 20'sd3) >>> 4);
         default:   pred = '0;
      endcase

      total = base + pred;
      if (total < -20'sd32768) begin
         clamped = -16'sd32768;
      end else if (total > 20'sd32767) begin
         clamped = 16'sd32767;
      end else begin
         clamped = total[SampleWidth-1:0];
      end
      wrapped = clamped[HistWidth-1:0];

      index_in  = index_ff;
      newer_in  = newer_ff;
      older_in  = older_ff;
      sample_in = sample_ff;
      last_in   = last_ff;
      ended_in  = ended_ff;
      valid_in  = valid_ff && !rsp_tready;
      if (step) begin
         index_in  = index_ff + 1'b1;
         older_in  = s1[HistWidth-1:0];
         newer_in  = wrapped;
         sample_in = {wrapped, 1'b0};
         last_in   = (index_ff == LAST_INDEX);
         ended_in  = head_entry.end_flag;
         valid_in  = 1'b1;
      end

      rsp_tvalid = valid_ff;
      rsp_tdata  = sample_ff;
      rsp_tlast  = last_ff;
      rsp_tuser  = ended_ff;
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      last_ff   <= last_in;
      ended_ff  <= ended_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         newer_ff <= '0;
         older_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         newer_ff <= newer_in;
         older_ff <= older_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/brr_block_sample_decoder.sv
`default_nettype none

// Decodes one 9-byte BRR block per input word into sixteen signed 16-bit PCM
// samples, high nibble of each payload byte first. The decode unit produces one
// sample per cycle while the output is not stalled, and blocks stream back to
// back at that rate; the input side keeps accepting into a small block queue
// while samples wait on the output. A word with the start flag clears the
// two-sample history; after a block with the end bit, blocks are dropped without
// output until the next start. An accepted block is first written into the
// queue, and its first sample then goes through the registered output stage.
module brr_block_sample_decoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // block_header[7:0], payload_front[39:8], payload_back[71:40]
   input  wire logic        req_tuser,   // start_stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // pcm_sample[15:0]
   output logic             rsp_tlast,
   output logic             rsp_tuser    // stream_ended
);
   import brr_pkg::*;

   logic          push;
   brr_entry_type push_entry;
   logic          queue_full;
   logic          pop;
   logic          head_valid;
   brr_entry_type head_entry;

   brr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   brr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   brr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: hdl/brr_checker.sv
`default_nettype none

module brr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [71:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   logic unused_req;
   assign unused_req = req_tvalid ^ req_tready ^ (^req_tdata) ^ req_tuser ^ rsp_tlast;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_even: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == 1'b0)
      else $error("decoded sample is odd");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind brr_block_sample_decoder brr_checker u_brr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: test/tb_brr_block_sample_decoder.sv
module tb_brr_block_sample_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import brr_pkg::*;

   localparam int StallLimit   = 3000;
   localparam int DrainCycles  = 24;
   localparam int PhaseBlocks  = 70;

   typedef struct packed {
      logic [15:0] pcm;
      logic        last;
      logic        ended;
   } pcm_word_type;

   class brr_pcm_board;
      int           older_hist;
      int           newer_hist;
      bit           stream_over;
      pcm_word_type pcm_due[$];
      int           mismatches;
      int           decoded_blocks;
      int           dropped_blocks;
      int           samples_seen;

      function new();
         older_hist     = 0;
         newer_hist     = 0;
         stream_over    = 1'b0;
         mismatches     = 0;
         decoded_blocks = 0;
         dropped_blocks = 0;
         samples_seen   = 0;
      endfunction

      function int pending();
         return pcm_due.size();
      endfunction

      // Decodes one accepted block word and queues its sixteen samples, or counts it as dropped after an end flag.
      function int take_block(bit start, logic [7:0] header, logic [63:0] payload);
         int             shift_range;
         brr_filter_type flt;
         bit             end_bit;
         logic [7:0]     octet;
         logic [3:0]     nib;
         logic [14:0]    w;
         int             n;
         int             v;
         int             s1;
         int             s2;
         pcm_word_type   e;
         shift_range = header[7:4];
         flt         = brr_filter_type'(header[3:2]);
         end_bit     = header[0];
         if (start) begin
            older_hist  = 0;
            newer_hist  = 0;
            stream_over = 1'b0;
         end
         if (stream_over) begin
            dropped_blocks++;
            return 0;
         end
         for (int k = 0; k < 16; k++) begin
            octet = payload[8*(k/2) +: 8];
            nib   = (k % 2 == 0) ? octet[7:4] : octet[3:0];
            n     = nib;
            if (n >= 8) begin
               n -= 16;
            end
            if (shift_range < RANGE_LIMIT) begin
               v = (n <<< shift_range) >>> 1;
            end else begin
               v = (n < 0) ? -2048 : 0;
            end
            s1 = newer_hist;
            s2 = older_hist;
            case (flt)
               FLT_ONE: begin
                  v += s1 + ((-s1) >>> 4);
               end
               FLT_TWO: begin
                  v += 2 * s1 + ((-3 * s1) >>> 5) - s2 + (s2 >>> 4);
               end
               FLT_THREE: begin
                  v += 2 * s1 + ((-13 * s1) >>> 6) - s2 + ((3 * s2) >>> 4);
               end
               default: begin
               end
            endcase
            if (v < -32768) begin
               v = -32768;
            end
            if (v > 32767) begin
               v = 32767;
            end
            w = v[14:0];
            v = $signed(w);
            older_hist = newer_hist;
            newer_hist = v;
            e.pcm   = {w, 1'b0};
            e.last  = (k == 15);
            e.ended = end_bit;
            pcm_due.insert(pcm_due.size(), e);
         end
         if (end_bit) begin
            stream_over = 1'b1;
         end
         decoded_blocks++;
         return 16;
      endfunction

      function void flag(string field, logic [15:0] want, logic [15:0] got);
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      endfunction

      function void check_sample(logic [15:0] pcm, logic last, logic over);
         pcm_word_type e;
         if (pcm_due.size() == 0) begin
            flag("unexpected sample", 16'hxxxx, pcm);
            return;
         end
         e = pcm_due.pop_front();
         samples_seen++;
         if (pcm !== e.pcm) begin
            flag("pcm_sample", e.pcm, pcm);
         end
         if (last !== e.last) begin
            flag("last_of_block", 16'(e.last), 16'(last));
         end
         if (over !== e.ended) begin
            flag("stream_ended", 16'(e.ended), 16'(over));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   brr_pcm_board board;
   int           sender_idle_pct;
   int           rsp_stall_pct;
   int           quiet_cycles;

   brr_block_sample_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_sample(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Watchdog expired with %0d samples outstanding.", board.pending());
         $display("** brr_block_sample_decoder: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] make_header(int shift_range, brr_filter_type flt, bit end_bit);
      return {4'(shift_range), flt, 1'($urandom_range(1)), end_bit};
   endfunction

   // The block word is held until the decoder takes it, then handed to the board.
   task automatic send_block(bit start, logic [7:0] header, logic [31:0] front,
                             logic [31:0] back);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= {back, front, header};
      do begin
         @(posedge clock);
      end while (!req_tready);
      void'(board.take_block(start, header, {back, front}));
   endtask

   task automatic drain_samples();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() > 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_block();
      bit             start;
      int             shift_range;
      logic [31:0]    front;
      logic [31:0]    back;
      brr_filter_type flt;
      if (board.stream_over) begin
         start = ($urandom_range(9) < 7);
      end else begin
         start = ($urandom_range(99) < 8);
      end
      shift_range = ($urandom_range(1) == 1) ? $urandom_range(8, 12) : $urandom_range(15);
      flt         = brr_filter_type'($urandom_range(3));
      case ($urandom_range(7))
         0: begin
            front = 32'h8888_8888;
            back  = 32'h8888_8888;
         end
         1: begin
            front = 32'h7777_7777;
            back  = 32'h7777_7777;
         end
         default: begin
            front = $urandom;
            back  = $urandom;
         end
      endcase
      send_block(start, make_header(shift_range, flt, $urandom_range(13) == 0), front, back);
   endtask

   initial begin
      int idle_plan[4];
      int stall_plan[4];
      int target;
      board           = new();
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tuser       = 1'b0;
      req_tdata       = '0;
      rsp_tready      = 1'b0;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      quiet_cycles    = 0;
      idle_plan       = '{0, 72, 0, 12};
      stall_plan      = '{0, 0, 72, 12};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_block(1'b1, make_header(0, FLT_NONE, 1'b0), 32'h0000_0000, 32'h0000_0000);
      send_block(1'b0, make_header(12, FLT_NONE, 1'b0), 32'hffff_ffff, 32'hffff_ffff);
      send_block(1'b0, make_header(12, FLT_NONE, 1'b0), 32'h8888_8888, 32'h8888_8888);
      send_block(1'b0, make_header(12, FLT_ONE, 1'b0), 32'h7777_7777, 32'h7777_7777);
      send_block(1'b0, make_header(13, FLT_NONE, 1'b0), 32'h80f0_7f19, 32'h6e5d_c4b3);
      send_block(1'b0, make_header(14, FLT_ONE, 1'b0), 32'h80f0_7f19, 32'h6e5d_c4b3);
      send_block(1'b0, make_header(15, FLT_TWO, 1'b0), 32'hffff_ffff, 32'h8888_8888);
      send_block(1'b1, make_header(12, FLT_TWO, 1'b0), 32'h7777_7777, 32'h7777_7777);
      send_block(1'b0, make_header(12, FLT_TWO, 1'b0), 32'h8888_8888, 32'h8888_8888);
      send_block(1'b0, make_header(12, FLT_THREE, 1'b0), 32'h7878_7878, 32'h8787_8787);
      send_block(1'b0, make_header(12, FLT_THREE, 1'b0), 32'h7777_7777, 32'h7777_7777);
      send_block(1'b0, make_header(11, FLT_THREE, 1'b0), 32'h8888_8888, 32'h8888_8888);
      send_block(1'b0, make_header(5, FLT_ONE, 1'b0), 32'h0123_4567, 32'h89ab_cdef);
      send_block(1'b0, make_header(9, FLT_TWO, 1'b1), 32'hfedc_ba98, 32'h7654_3210);
      send_block(1'b0, make_header(12, FLT_NONE, 1'b0), 32'h7777_7777, 32'h7777_7777);
      send_block(1'b0, make_header(3, FLT_THREE, 1'b1), 32'h1234_5678, 32'h9abc_def0);
      send_block(1'b1, make_header(12, FLT_ONE, 1'b1), 32'h8888_8888, 32'h7777_7777);
      send_block(1'b0, make_header(1, FLT_NONE, 1'b0), 32'h5555_5555, 32'haaaa_aaaa);
      send_block(1'b1, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
      send_block(1'b1, make_header(12, FLT_THREE, 1'b0), 32'h8080_8080, 32'h0808_0808);
      send_block(1'b0, make_header(7, FLT_TWO, 1'b0), 32'ha5a5_5a5a, 32'h3c3c_c3c3);
      drain_samples();

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_plan[phase];
         rsp_stall_pct   = stall_plan[phase];
         target          = board.decoded_blocks + PhaseBlocks;
         while (board.decoded_blocks < target) begin
            send_random_block();
         end
         // The sender holds off here until every queued sample has come out.
         drain_samples();
      end

      rsp_stall_pct = 0;
      repeat (DrainCycles) @(posedge clock);

      $display("Checked %0d samples from %0d decoded blocks;", board.samples_seen,
               board.decoded_blocks);
      $display("%0d blocks were dropped after an end flag.", board.dropped_blocks);
      $display("Flow control ran without gaps, with sender gaps, with receiver stalls and with both.");
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("** brr_block_sample_decoder: PASSED **");
      end else begin
         $display("** brr_block_sample_decoder: FAILED **");
      end
      $finish;
   end

endmodule
